### rtl/assert_macros.svh
// assertion macros included by the tokenizer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### rtl/cbt_pkg.sv
// types and constants of the byte tokenizer
package cbt_pkg;

   localparam int MAX_WORD_CHARS = 8;
   localparam int LINE_BITS      = 16;
   localparam int TEXT_BITS      = 8 * MAX_WORD_CHARS;
   localparam int LEN_BITS       = 8;
   localparam int QUEUE_DEPTH    = 4;
   localparam int QPTR_BITS      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS      = QPTR_BITS + 1;

   localparam logic [TEXT_BITS-1:0] KW_INT    = TEXT_BITS'(64'h0000_0000_0074_6e69);
   localparam logic [TEXT_BITS-1:0] KW_RETURN = TEXT_BITS'(64'h0000_6e72_7574_6572);

   localparam logic [7:0] CH_NEWLINE = 8'h0a;

   typedef enum logic [1:0] {
      MODE_IDLE   = 2'd0,
      MODE_IDENT  = 2'd1,
      MODE_NUMBER = 2'd2
   } mode_type;

   typedef enum logic [3:0] {
      TOK_EOF     = 4'd0,
      TOK_INT     = 4'd1,
      TOK_RETURN  = 4'd2,
      TOK_IDENT   = 4'd3,
      TOK_NUMBER  = 4'd4,
      TOK_PLUS    = 4'd5,
      TOK_MINUS   = 4'd6,
      TOK_STAR    = 4'd7,
      TOK_SLASH   = 4'd8,
      TOK_ASSIGN  = 4'd9,
      TOK_SEMI    = 4'd10,
      TOK_LPAREN  = 4'd11,
      TOK_RPAREN  = 4'd12,
      TOK_LBRACE  = 4'd13,
      TOK_RBRACE  = 4'd14,
      TOK_UNKNOWN = 4'd15
   } kind_type;

   typedef struct packed {
      kind_type               kind;
      logic [LINE_BITS-1:0]   start_line;
      logic [TEXT_BITS-1:0]   text;
      logic [LEN_BITS-1:0]    text_length;
      logic                   truncated;
      logic                   last;
   } token_type;

   function automatic logic is_letter(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return c == " " || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic kind_type op_kind(input logic [7:0] c);
      kind_type k;
      case (c)
         "+":     k = TOK_PLUS;
         "-":     k = TOK_MINUS;
         "*":     k = TOK_STAR;
         "/":     k = TOK_SLASH;
         "=":     k = TOK_ASSIGN;
         ";":     k = TOK_SEMI;
         "(":     k = TOK_LPAREN;
         ")":     k = TOK_RPAREN;
         "{":     k = TOK_LBRACE;
         "}":     k = TOK_RBRACE;
         default: k = TOK_UNKNOWN;
      endcase
      return k;
   endfunction

endpackage

### rtl/c_subset_byte_tokenizer.sv
// byte-serial tokenizer for a small c subset
// a token enters the queue as its beat is accepted; rsp presents the queue head
// one byte beat per cycle while req_tready is high; a beat yields up to two tokens
// a four-entry token queue sets the pace: req_tready is high while it holds two or fewer
// reset: synchronous, active high; scanner idle, line count one, token queue emptied
`include "assert_macros.svh"

module c_subset_byte_tokenizer (
   input  logic        clock,
   input  logic        reset,
   // source byte channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] byte_in
   input  logic        req_tuser,   // [0] end_in
   // token channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,   // [3:0] kind, [19:4] start_line, [83:20] text,
                                    // [91:84] text_length, [92] truncated, [95:93] zero
   output logic        rsp_tlast    // last token caused by the source beat
);
   import cbt_pkg::*;

   localparam logic [LINE_BITS-1:0] LINE_ONE = LINE_BITS'(1);
   localparam logic [LINE_BITS-1:0] LINE_MAX = '1;

   // scanner state
   mode_type               mode_ff,  mode_in;
   logic [TEXT_BITS-1:0]   buf_ff,   buf_in;
   logic [LEN_BITS-1:0]    len_ff,   len_in;
   logic [LINE_BITS-1:0]   line_ff,  line_in;
   logic [LINE_BITS-1:0]   wline_ff, wline_in;

   // token queue between scanner and rsp side
   token_type              q_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   head_ff,  head_in;
   logic [QCNT_BITS-1:0]   count_ff, count_in;
   logic [QPTR_BITS-1:0]   tail;

   logic                   req_accept;
   logic                   rsp_accept;
   logic [7:0]             ch;
   logic                   end_mark;
   token_type              tok_a, tok_b;   // up to two tokens per beat, in order
   token_type              word_tok;
   logic [1:0]             n_tok;
   token_type              head_tok;

   assign ch         = req_tdata;
   assign end_mark   = req_tuser;
   assign req_tready = (count_ff <= QCNT_BITS'(QUEUE_DEPTH - 2));
   assign req_accept = req_tvalid && req_tready;
   assign rsp_accept = rsp_tvalid && rsp_tready;

   // token for the pending word, built from the current state
   always_comb begin
      logic trunc;
      trunc               = (len_ff > LEN_BITS'(MAX_WORD_CHARS));
      word_tok            = '0;
      word_tok.start_line = wline_ff;
      word_tok.text       = buf_ff;
      word_tok.text_length = len_ff;
      word_tok.truncated  = trunc;
      if (mode_ff == MODE_IDENT) begin
         if (!trunc && len_ff == LEN_BITS'(3) && buf_ff == KW_INT) begin
            word_tok.kind = TOK_INT;
         end else if (!trunc && len_ff == LEN_BITS'(6) && buf_ff == KW_RETURN) begin
            word_tok.kind = TOK_RETURN;
         end else begin
            word_tok.kind = TOK_IDENT;
         end
      end else begin
         word_tok.kind = TOK_NUMBER;
      end
   end

   // scanner: next state and the tokens of the accepted beat
   always_comb begin
      token_type op_tok;
      logic      extend;
      logic      flush;
      mode_in  = mode_ff;
      buf_in   = buf_ff;
      len_in   = len_ff;
      line_in  = line_ff;
      wline_in = wline_ff;
      tok_a    = '0;
      tok_b    = '0;
      n_tok    = 2'd0;
      op_tok   = '0;
      op_tok.start_line = line_ff;
      extend   = ((mode_ff == MODE_IDENT) && (is_letter(ch) || is_digit(ch)))
              || ((mode_ff == MODE_NUMBER) && is_digit(ch));
      flush    = (mode_ff != MODE_IDLE);

      if (req_accept) begin
         if (end_mark) begin
            // flush the pending word, then the end token; back to reset state
            op_tok.kind = TOK_EOF;
            if (flush) begin
               tok_a = word_tok;
               tok_b = op_tok;
               n_tok = 2'd2;
            end else begin
               tok_a = op_tok;
               n_tok = 2'd1;
            end
            mode_in  = MODE_IDLE;
            buf_in   = '0;
            len_in   = '0;
            line_in  = LINE_ONE;
            wline_in = LINE_ONE;
         end else if (extend) begin
            // append to the word, keeping only the first characters
            for (int i = 0; i < MAX_WORD_CHARS; i++) begin
               if (len_ff == LEN_BITS'(i)) begin
                  buf_in[8*i +: 8] = ch;
               end
            end
            if (len_ff != '1) begin
               len_in = len_ff + LEN_BITS'(1);
            end
         end else begin
            if (flush) begin
               tok_a   = word_tok;
               n_tok   = 2'd1;
               mode_in = MODE_IDLE;
               buf_in  = '0;
               len_in  = '0;
            end
            if (is_space(ch)) begin
               if (ch == CH_NEWLINE && line_ff != LINE_MAX) begin
                  line_in = line_ff + LINE_ONE;
               end
            end else if (is_letter(ch) || is_digit(ch)) begin
               // the byte that ended a word may open the next one
               mode_in  = is_letter(ch) ? MODE_IDENT : MODE_NUMBER;
               buf_in   = TEXT_BITS'(ch);
               len_in   = LEN_BITS'(1);
               wline_in = line_ff;
            end else begin
               op_tok.kind = op_kind(ch);
               if (flush) begin
                  tok_b = op_tok;
                  n_tok = 2'd2;
               end else begin
                  tok_a = op_tok;
                  n_tok = 2'd1;
               end
            end
         end

         // mark the final token of this beat
         if (n_tok == 2'd2) begin
            tok_b.last = 1'b1;
         end else if (n_tok == 2'd1) begin
            tok_a.last = 1'b1;
         end
      end
   end

   // queue pointers
   assign tail = head_ff + count_ff[QPTR_BITS-1:0];

   always_comb begin
      head_in  = head_ff + QPTR_BITS'(rsp_accept);
      count_in = count_ff + QCNT_BITS'(n_tok) - QCNT_BITS'(rsp_accept);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         buf_ff   <= '0;
         len_ff   <= '0;
         line_ff  <= LINE_ONE;
         wline_ff <= LINE_ONE;
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         mode_ff  <= mode_in;
         buf_ff   <= buf_in;
         len_ff   <= len_in;
         line_ff  <= line_in;
         wline_ff <= wline_in;
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   // token storage, no reset needed
   always_ff @(posedge clock) begin
      if (n_tok != 2'd0) begin
         q_ff[tail] <= tok_a;
      end
      if (n_tok == 2'd2) begin
         q_ff[tail + QPTR_BITS'(1)] <= tok_b;
      end
   end

   // rsp side presents the queue head
   assign head_tok   = q_ff[head_ff];
   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tlast  = head_tok.last;
   assign rsp_tdata  = {3'b000, head_tok.truncated, head_tok.text_length, head_tok.text,
                        head_tok.start_line, head_tok.kind};

   // checks
   `ASSERT_IMP(a_queue_bound, clock, reset, 1'b1, count_ff <= QCNT_BITS'(QUEUE_DEPTH))
   `ASSERT_NEXT(a_end_restarts, clock, reset, req_accept && end_mark, mode_ff == MODE_IDLE && line_ff == LINE_ONE)
   `ASSERT_IMP(a_idle_no_word, clock, reset, mode_ff == MODE_IDLE, len_ff == '0 && buf_ff == '0)

endmodule

### tb/sv/testbench.sv
// self-checking testbench for the byte tokenizer against a token predictor
`timescale 1ns / 100ps

module testbench;
   import cbt_pkg::*;

   localparam int HALF_PERIOD    = 10;     // 20 ns clock
   localparam int RESET_CYCLES   = 6;
   localparam int WATCHDOG_LIMIT = 2000;   // cycles in a row with no beat on either side
   localparam int RANDOM_BEATS   = 1040;   // source beats in the random part
   localparam int DRAIN_EVERY    = 300;    // random beats between full drains
   localparam int SETTLE_CYCLES  = 20;     // quiet time after the last token
   localparam int MAX_PRINTED    = 40;     // mismatch lines printed, the rest only counted

   // token predictor and store of tokens still owed by the block
   class token_scoreboard;
      typedef struct {
         kind_type             kind;
         logic [LINE_BITS-1:0] line;
         logic [TEXT_BITS-1:0] text;
         logic [LEN_BITS-1:0]  length;
         logic                 truncated;
         logic                 last;
      } owed_type;

      mode_type             mode;
      logic [TEXT_BITS-1:0] word;
      logic [LEN_BITS-1:0]  word_len;
      logic [LINE_BITS-1:0] line_no;
      logic [LINE_BITS-1:0] word_line;
      owed_type             due[$];
      int                   errors;

      function new();
         errors = 0;
         clear_scan();
      endfunction

      function void clear_scan();
         mode      = MODE_IDLE;
         word      = '0;
         word_len  = '0;
         line_no   = 1;
         word_line = 1;
      endfunction

      function bit letter_char(logic [7:0] ch);
         return ch inside {["a":"z"], ["A":"Z"], "_"};
      endfunction

      function bit digit_char(logic [7:0] ch);
         return ch inside {["0":"9"]};
      endfunction

      // space, tab, newline, vertical tab, form feed, carriage return
      function bit blank_char(logic [7:0] ch);
         return ch inside {8'h20, [8'h09:8'h0d]};
      endfunction

      function kind_type operator_kind(logic [7:0] ch);
         case (ch)
            "+":     return TOK_PLUS;
            "-":     return TOK_MINUS;
            "*":     return TOK_STAR;
            "/":     return TOK_SLASH;
            "=":     return TOK_ASSIGN;
            ";":     return TOK_SEMI;
            "(":     return TOK_LPAREN;
            ")":     return TOK_RPAREN;
            "{":     return TOK_LBRACE;
            "}":     return TOK_RBRACE;
            default: return TOK_UNKNOWN;
         endcase
      endfunction

      // only the first few characters are stored, the length saturates
      function void append_char(logic [7:0] ch);
         if (word_len < MAX_WORD_CHARS) word[8*word_len +: 8] = ch;
         if (word_len != '1) word_len++;
      endfunction

      function void start_word(mode_type m, logic [7:0] ch);
         mode      = m;
         word      = '0;
         word_len  = '0;
         word_line = line_no;
         append_char(ch);
      endfunction

      function owed_type plain_token(kind_type k);
         owed_type t;
         t.kind      = k;
         t.line      = line_no;
         t.text      = '0;
         t.length    = '0;
         t.truncated = 1'b0;
         t.last      = 1'b0;
         return t;
      endfunction

      // a truncated word never matches a keyword
      function owed_type flush_word();
         owed_type t;
         logic     long_word;
         long_word = word_len > MAX_WORD_CHARS;
         t.kind = TOK_NUMBER;
         if (mode == MODE_IDENT) begin
            if (!long_word && word_len == 3 && word == KW_INT) t.kind = TOK_INT;
            else if (!long_word && word_len == 6 && word == KW_RETURN) t.kind = TOK_RETURN;
            else t.kind = TOK_IDENT;
         end
         t.line      = word_line;
         t.text      = word;
         t.length    = word_len;
         t.truncated = long_word;
         t.last      = 1'b0;
         mode        = MODE_IDLE;
         word        = '0;
         word_len    = '0;
         return t;
      endfunction

      // called once per accepted source beat
      function void note_byte(logic [7:0] ch, logic at_end);
         owed_type made[$];
         owed_type t;
         if (at_end) begin
            if (mode != MODE_IDLE) made.push_back(flush_word());
            made.push_back(plain_token(TOK_EOF));
            clear_scan();
         end else if (mode == MODE_IDENT && (letter_char(ch) || digit_char(ch))) begin
            append_char(ch);
         end else if (mode == MODE_NUMBER && digit_char(ch)) begin
            append_char(ch);
         end else begin
            // the byte that ends a word is handled on its own
            if (mode != MODE_IDLE) made.push_back(flush_word());
            if (blank_char(ch)) begin
               if (ch == CH_NEWLINE && line_no != '1) line_no++;
            end else if (letter_char(ch)) begin
               start_word(MODE_IDENT, ch);
            end else if (digit_char(ch)) begin
               start_word(MODE_NUMBER, ch);
            end else begin
               made.push_back(plain_token(operator_kind(ch)));
            end
         end
         foreach (made[i]) begin
            t = made[i];
            t.last = (i == made.size() - 1);
            due.push_back(t);
         end
      endfunction

      function int pending();
         return due.size();
      endfunction

      task report(string what);
         errors++;
         if (errors <= MAX_PRINTED) $display("mismatch at %0t ns: %s", $time, what);
      endtask

      // called once per accepted token beat
      task check_token(logic [95:0] data, logic tlast);
         owed_type want;
         if (due.size() == 0) begin
            report($sformatf("token with none owed, tdata %h", data));
            return;
         end
         want = due.pop_front();
         if (data[3:0] !== want.kind)
            report($sformatf("kind %0d, owed %s", data[3:0], want.kind.name()));
         if (data[19:4] !== want.line)
            report($sformatf("start_line %0d, owed %0d", data[19:4], want.line));
         if (data[83:20] !== want.text)
            report($sformatf("text %h, owed %h", data[83:20], want.text));
         if (data[91:84] !== want.length)
            report($sformatf("text_length %0d, owed %0d", data[91:84], want.length));
         if (data[92] !== want.truncated)
            report($sformatf("truncated %b, owed %b", data[92], want.truncated));
         if (data[95:93] !== 3'b000)
            report($sformatf("pad bits %b, owed zero", data[95:93]));
         if (tlast !== want.last)
            report($sformatf("tlast %b, owed %b", tlast, want.last));
      endtask
   endclass

   // clock, reset and the block's ports; the inputs driven here are known from time zero
   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;
   logic        req_tuser  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [95:0] rsp_tdata;
   logic        rsp_tlast;

   token_scoreboard sb = new();

   bit    no_idle     = 1'b0;   // set for stretches with no gaps on either side
   int    work_beats  = 0;      // source beats accepted so far
   int    quiet_count = 0;      // watchdog count
   string ident_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";

   c_subset_byte_tokenizer u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   // gap length: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [7:0] blank_byte(int i);
      case (i)
         0:       return 8'h20;   // space
         1:       return 8'h09;   // tab
         2:       return CH_NEWLINE;
         3:       return 8'h0b;   // vertical tab
         4:       return 8'h0c;   // form feed
         default: return 8'h0d;   // carriage return
      endcase
   endfunction

   function automatic logic [7:0] operator_byte(int i);
      case (i)
         0:       return "+";
         1:       return "-";
         2:       return "*";
         3:       return "/";
         4:       return "=";
         5:       return ";";
         6:       return "(";
         7:       return ")";
         8:       return "{";
         default: return "}";
      endcase
   endfunction

   // word length: mostly short, often around the stored limit, rarely past saturation
   function automatic int pick_word_len();
      int r;
      r = $urandom_range(0, 999);
      if (r < 700) return $urandom_range(1, 5);
      if (r < 900) return $urandom_range(6, 10);
      if (r < 995) return $urandom_range(11, 24);
      return $urandom_range(250, 270);
   endfunction

   // one source beat; tvalid stays high into the next beat unless a gap is drawn
   task automatic send_beat(logic [7:0] ch, logic at_end);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ch;
      req_tuser  <= at_end;
      do @(posedge clock); while (!req_tready);
      sb.note_byte(ch, at_end);
      work_beats++;
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_beat(s[i], 1'b0);
   endtask

   // random identifier or number of n characters
   task automatic send_word(int n, bit numeric);
      logic [7:0] ch;
      for (int i = 0; i < n; i++) begin
         if (numeric) ch = "0" + 8'($urandom_range(0, 9));
         else if (i == 0) ch = ident_chars[$urandom_range(0, 52)];
         else ch = ident_chars[$urandom_range(0, 62)];
         send_beat(ch, 1'b0);
      end
   endtask

   // sender holds off until every owed token has come back
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   // token sink with random back-pressure, one ready update per edge
   initial begin
      int hold;
      hold = 0;
      forever begin
         @(posedge clock);
         if (hold > 0) hold--;
         else hold = pick_gap();
         rsp_tready <= (hold == 0);
      end
   end

   // token monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_token(rsp_tdata, rsp_tlast);
   end

   // watchdog on cycles without any beat
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_count <= 0;
      else quiet_count <= quiet_count + 1;
      if (quiet_count >= WATCHDOG_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin
      int r;
      int next_drain;
      int stop_at;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---- directed text ----
      // braces, keyword int, ident with digit, assign, letter right after digits
      send_text("{int r9=12ab;}");
      // keyword return, every remaining operator, lone underscore
      send_text("return(_+-*/)");
      // all six blank bytes, the newline bumps the line count
      for (int i = 0; i < 6; i++) send_beat(blank_byte(i), 1'b0);
      // bytes with no meaning: nul, top bit set, all ones, plain punctuation
      send_beat(8'h00, 1'b0);
      send_beat(8'h80, 1'b0);
      send_beat(8'hff, 1'b0);
      send_beat("@", 1'b0);
      // words past the stored limit, keyword prefix that is too long
      send_text(" intintint 1234567890 ");
      // length saturation
      send_word(300, 1'b0);
      // end marker with a word pending, data ignored
      send_text(" abc");
      send_beat(8'hff, 1'b1);
      // end marker while idle
      send_beat(8'h00, 1'b1);
      drain();

      // ---- random source text ----
      stop_at    = work_beats + RANDOM_BEATS;
      next_drain = work_beats + DRAIN_EVERY;
      while (work_beats < stop_at) begin
         // occasional stretch without any gaps
         if ($urandom_range(0, 59) == 0) no_idle = !no_idle;
         r = $urandom_range(0, 99);
         if (r < 10) begin
            // keywords and near misses
            case ($urandom_range(0, 9))
               0, 1:    send_text("int");
               2, 3:    send_text("return");
               4:       send_text("in");
               5:       send_text("intx");
               6:       send_text("retur");
               7:       send_text("Int");
               8:       send_text("returns");
               default: send_text("return1");
            endcase
         end else if (r < 30) begin
            send_word(pick_word_len(), 1'b0);
         end else if (r < 45) begin
            send_word(pick_word_len(), 1'b1);
         end else if (r < 68) begin
            send_beat(operator_byte($urandom_range(0, 9)), 1'b0);
         end else if (r < 76) begin
            send_beat(blank_byte($urandom_range(0, 5)), 1'b0);
         end else if (r < 84) begin
            // any byte at all
            send_beat(8'($urandom_range(0, 255)), 1'b0);
         end else if (r < 88) begin
            // end marker with random ignored data
            send_beat(8'($urandom_range(0, 255)), 1'b1);
         end else begin
            // number running straight into an identifier
            send_word($urandom_range(1, 4), 1'b1);
            send_word($urandom_range(1, 4), 1'b0);
         end
         // half the time no separator, so a byte may end one token and make another
         if ($urandom_range(0, 1) == 0) send_beat(blank_byte($urandom_range(0, 5)), 1'b0);
         if (work_beats >= next_drain) begin
            drain();
            next_drain = work_beats + DRAIN_EVERY;
         end
      end
      no_idle = 1'b0;

      // ---- wind down ----
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
